### src/ntcadc_pkg.sv
// Shared types and constants for the NTC reading to temperature converter.
// Holds the controller state type, limits, resolution codes and the ROM table.
// No dependencies.
package ntcadc_pkg;

    // Address space of the table ROM (8-bit index).
    localparam int unsigned ROM_SLOTS = 256;
    localparam int unsigned ROM_AW = 8;
    localparam int unsigned NTC_ROM_ENTRIES = 140;

    // Fault window for the averaged reading.
    localparam logic [11:0] ADC_HIGH_LIMIT = 12'h0FF7;
    localparam logic [11:0] ADC_LOW_LIMIT = 12'h0008;

    // Table index of 0 degrees C (table starts at -20 C, one entry per degree).
    localparam logic [9:0] ZERO_C_INDEX = 10'd20;

    // Resolution codes; the spare code gives no rounding.
    localparam logic [1:0] RES_TENTH = 2'd0;
    localparam logic [1:0] RES_HALF = 2'd1;
    localparam logic [1:0] RES_WHOLE = 2'd2;
    localparam logic [1:0] RES_SPARE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP_HI,
        ST_CLAMP_LO,
        ST_WALK,
        ST_DIV,
        ST_FINAL
    } state_t;

    // B = 3380, 10k pull-up divider, -20 C .. +119 C, decreasing.
    localparam logic [11:0] NTC_ROM [0:NTC_ROM_ENTRIES-1] = '{
        12'd3568, 12'd3546, 12'd3523, 12'd3499, 12'd3475,
        12'd3449, 12'd3424, 12'd3397, 12'd3370, 12'd3342,
        12'd3314, 12'd3285, 12'd3255, 12'd3225, 12'd3194,
        12'd3162, 12'd3130, 12'd3098, 12'd3064, 12'd3031,
        12'd2996, 12'd2962, 12'd2927, 12'd2891, 12'd2855,
        12'd2818, 12'd2781, 12'd2744, 12'd2706, 12'd2669,
        12'd2630, 12'd2592, 12'd2553, 12'd2515, 12'd2476,
        12'd2437, 12'd2398, 12'd2359, 12'd2319, 12'd2280,
        12'd2241, 12'd2202, 12'd2163, 12'd2125, 12'd2086,
        12'd2048, 12'd2009, 12'd1971, 12'd1933, 12'd1896,
        12'd1859, 12'd1822, 12'd1785, 12'd1749, 12'd1714,
        12'd1678, 12'd1643, 12'd1607, 12'd1575, 12'd1541,
        12'd1508, 12'd1475, 12'd1443, 12'd1411, 12'd1379,
        12'd1349, 12'd1319, 12'd1289, 12'd1259, 12'd1231,
        12'd1203, 12'd1175, 12'd1148, 12'd1122, 12'd1096,
        12'd1070, 12'd1045, 12'd1021, 12'd997,  12'd973,
        12'd950,  12'd927,  12'd905,  12'd883,  12'd862,
        12'd842,  12'd822,  12'd802,  12'd783,  12'd764,
        12'd746,  12'd728,  12'd710,  12'd693,  12'd677,
        12'd661,  12'd645,  12'd629,  12'd614,  12'd599,
        12'd585,  12'd571,  12'd558,  12'd544,  12'd531,
        12'd518,  12'd506,  12'd495,  12'd483,  12'd471,
        12'd460,  12'd449,  12'd439,  12'd428,  12'd418,
        12'd409,  12'd399,  12'd389,  12'd381,  12'd372,
        12'd363,  12'd354,  12'd346,  12'd339,  12'd331,
        12'd323,  12'd316,  12'd308,  12'd301,  12'd295,
        12'd288,  12'd282,  12'd275,  12'd269,  12'd263,
        12'd257,  12'd251,  12'd246,  12'd241,  12'd236
    };

    // Slots past the populated part of the ROM read as zero.
    function automatic logic [11:0] rom_value(input logic [ROM_AW-1:0] addr);
        logic [11:0] val;
        val = 12'd0;
        if (addr < ROM_AW'(NTC_ROM_ENTRIES)) begin
            val = NTC_ROM[addr];
        end
        return val;
    endfunction

endpackage

### src/ntc_adc_to_temperature.sv
// NTC thermistor reading to temperature converter, top level.
// Depends on ntcadc_pkg (state type, limits, resolution codes, ROM table).
//
// Takes one averaged 12-bit ADC reading per item and returns one item with a
// temperature in tenths of a degree C (two's complement) and a fault flag.
// A reading above 0xFF7 or below 8 flags a sensor fault and returns 0. Other
// readings are clamped to the table ends, located in a decreasing ROM table
// (one entry per degree from -20 C), interpolated to tenths with a serial
// divider and rounded about zero to 0.1, 0.5 or 1.0 degree according to the
// resolution register. One item is in flight at a time. A fault item goes
// from accept straight to the final state. A valid reading passes the high
// and low clamp states, then walks 1 .. TABLE_ENTRIES table entries, one per
// cycle through the single registered ROM read port, then runs the restoring
// divider, one quotient bit per cycle, whenever the reading lies between two
// entries (a reading clamped to the first entry skips it). The final state
// waits for a free output register. The result sits in an output register,
// so the next item is accepted while a result waits to be taken.
// The resolution register is written over its own channel, always ready,
// and must only be written while no item is in flight.
module ntc_adc_to_temperature #(
    parameter int unsigned TABLE_ENTRIES = 140
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_resolution_mode,
    // reading in
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [11:0]        s_adc_average,
    // temperature out
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [11:0] m_temperature_tenths,
    output logic               m_sensor_error
);

    localparam int unsigned AW = ntcadc_pkg::ROM_AW;
    // Index of the last table entry in use.
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    ntcadc_pkg::state_t state_reg, state_next;

    logic [1:0]         mode_reg;
    logic [11:0]        x_reg, x_next;
    logic               err_reg, err_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [11:0]        hi_reg, hi_next;
    logic [11:0]        span_reg, span_next;
    logic [15:0]        rem_reg, rem_next;
    logic [3:0]         quo_reg, quo_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [11:0] m_temp_reg, m_temp_next;
    logic               m_err_reg, m_err_next;

    // ROM port: address chosen this cycle, data registered for the next.
    logic [AW-1:0]      rom_addr;
    logic [11:0]        rom_q_reg;

    // Walk and divider helpers.
    logic               walk_more;
    logic               div_go;
    logic [11:0]        diff;
    logic [15:0]        num;
    logic [15:0]        trial;

    // Final stage helpers.
    logic [3:0]         frac;
    logic signed [13:0] kdeg;
    logic signed [13:0] t_val;
    logic               neg;
    logic [12:0]        mag;
    logic [3:0]         r10;
    logic [3:0]         r5;
    logic [12:0]        mag_rnd;
    logic signed [13:0] t_rnd;
    logic               out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ntcadc_pkg::ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_temperature_tenths = m_temp_reg;
    assign m_sensor_error = m_err_reg;

    assign out_free  = !m_valid_reg || m_ready;

    // Keep walking while entries remain and the reading lies below the entry.
    assign walk_more = (idx_reg < LAST_IDX) && (x_reg < rom_q_reg);
    // Interpolate only inside a falling pair; otherwise the fraction stays 0.
    assign div_go    = (idx_reg != '0) && (hi_reg > rom_q_reg) && (x_reg >= rom_q_reg);
    assign diff      = x_reg - rom_q_reg;
    assign num       = ({4'd0, diff} << 3) + ({4'd0, diff} << 1);
    assign trial     = 16'({4'd0, span_reg} << cnt_reg);

    // Interpolated tenths, rounded up when the remainder exceeds half the span.
    assign frac  = quo_reg + ((rem_reg > {5'd0, span_reg[11:1]}) ? 4'd1 : 4'd0);
    assign kdeg  = 14'($signed({2'b00, idx_reg}) - $signed(ntcadc_pkg::ZERO_C_INDEX));
    assign t_val = (kdeg <<< 3) + (kdeg <<< 1) - $signed({10'd0, frac});
    assign neg   = t_val[13];
    assign mag   = neg ? 13'(-t_val) : 13'(t_val);

    // Remainder of the magnitude modulo 10 follows from the interpolation
    // split: t = 10*k - frac, so no divider is needed here.
    always_comb begin
        if (frac == 4'd0 || frac == 4'd10) begin
            r10 = 4'd0;
        end else if (neg) begin
            r10 = frac;
        end else begin
            r10 = 4'd10 - frac;
        end
        r5 = (r10 >= 4'd5) ? (r10 - 4'd5) : r10;
    end

    always_comb begin
        case (mode_reg)
            ntcadc_pkg::RES_HALF: begin
                mag_rnd = mag - {9'd0, r5} + ((r5 >= 4'd3) ? 13'd5 : 13'd0);
            end
            ntcadc_pkg::RES_WHOLE: begin
                mag_rnd = mag - {9'd0, r10} + ((r10 >= 4'd5) ? 13'd10 : 13'd0);
            end
            default: begin
                mag_rnd = mag;
            end
        endcase
        t_rnd = neg ? -$signed({1'b0, mag_rnd}) : $signed({1'b0, mag_rnd});
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ntcadc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_adc_average > ntcadc_pkg::ADC_HIGH_LIMIT ||
                        s_adc_average < ntcadc_pkg::ADC_LOW_LIMIT) begin
                        state_next = ntcadc_pkg::ST_FINAL;
                    end else begin
                        state_next = ntcadc_pkg::ST_CLAMP_HI;
                    end
                end
            end
            ntcadc_pkg::ST_CLAMP_HI: begin
                state_next = ntcadc_pkg::ST_CLAMP_LO;
            end
            ntcadc_pkg::ST_CLAMP_LO: begin
                state_next = ntcadc_pkg::ST_WALK;
            end
            ntcadc_pkg::ST_WALK: begin
                if (!walk_more) begin
                    if (div_go) begin
                        state_next = ntcadc_pkg::ST_DIV;
                    end else begin
                        state_next = ntcadc_pkg::ST_FINAL;
                    end
                end
            end
            ntcadc_pkg::ST_DIV: begin
                if (cnt_reg == 2'd0) begin
                    state_next = ntcadc_pkg::ST_FINAL;
                end
            end
            ntcadc_pkg::ST_FINAL: begin
                if (out_free) begin
                    state_next = ntcadc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ntcadc_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        x_next       = x_reg;
        err_next     = err_reg;
        idx_next     = idx_reg;
        hi_next      = hi_reg;
        span_next    = span_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_temp_next  = m_temp_reg;
        m_err_next   = m_err_reg;
        rom_addr     = '0;

        // Drop the valid flag once the item is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ntcadc_pkg::ST_IDLE: begin
                x_next   = s_adc_average;
                err_next = s_adc_average > ntcadc_pkg::ADC_HIGH_LIMIT ||
                           s_adc_average < ntcadc_pkg::ADC_LOW_LIMIT;
                // Fault and flat-pair paths see a zero fraction.
                span_next = '0;
                rem_next  = '0;
                quo_next  = '0;
                rom_addr  = '0;
            end
            ntcadc_pkg::ST_CLAMP_HI: begin
                // Clamp to the first entry, fetch the last.
                if (x_reg > rom_q_reg) begin
                    x_next = rom_q_reg;
                end
                rom_addr = LAST_IDX;
            end
            ntcadc_pkg::ST_CLAMP_LO: begin
                // Clamp to the last entry, start the walk at entry 0.
                if (x_reg < rom_q_reg) begin
                    x_next = rom_q_reg;
                end
                idx_next = '0;
                rom_addr = '0;
            end
            ntcadc_pkg::ST_WALK: begin
                if (walk_more) begin
                    // Advance: hold this entry as the upper bound.
                    hi_next  = rom_q_reg;
                    idx_next = idx_reg + 1'b1;
                    rom_addr = idx_reg + 1'b1;
                end else if (div_go) begin
                    span_next = hi_reg - rom_q_reg;
                    rem_next  = num;
                    quo_next  = '0;
                    cnt_next  = 2'd3;
                end
            end
            ntcadc_pkg::ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (rem_reg >= trial) begin
                    rem_next = rem_reg - trial;
                    quo_next = quo_reg | (4'd1 << cnt_reg);
                end
                cnt_next = cnt_reg - 2'd1;
            end
            ntcadc_pkg::ST_FINAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_err_next   = err_reg;
                    m_temp_next  = err_reg ? 12'sd0 : 12'(t_rnd);
                end
            end
            default: begin
                rom_addr = '0;
            end
        endcase
    end

    // Table ROM with a registered read.
    always_ff @(posedge aclk) begin
        rom_q_reg <= ntcadc_pkg::rom_value(rom_addr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ntcadc_pkg::ST_IDLE;
            mode_reg    <= ntcadc_pkg::RES_TENTH;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_resolution_mode;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        err_reg    <= err_next;
        idx_reg    <= idx_next;
        hi_reg     <= hi_next;
        span_reg   <= span_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        m_temp_reg <= m_temp_next;
        m_err_reg  <= m_err_next;
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for ntc_adc_to_temperature: predicts each temperature item
// from the NTC table in ntcadc_pkg and checks every result item against it.
// Depends on ntcadc_pkg and the ntc_adc_to_temperature RTL only.
module tb;

    localparam int unsigned TABLE_ENTRIES = 140;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned RANDOM_PHASES = 7;
    localparam int unsigned PHASE_ITEMS = 100;

    // One expected temperature item, laid out like the result channel.
    typedef struct packed {
        logic signed [11:0] tenths;
        logic               fault;
    } temp_item_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_resolution_mode;
    logic               s_valid;
    logic               s_ready;
    logic [11:0]        s_adc_average;
    logic               m_valid;
    logic               m_ready;
    logic signed [11:0] m_temperature_tenths;
    logic               m_sensor_error;

    // Bench copy of the resolution register and the queue of pending temperatures.
    logic [1:0]   res_mode;
    temp_item_t   pending_temps[$];
    int           mismatch_count;
    int unsigned  cycle_count;

    // Idle control shared by both sides, plus a receiver hold-off request.
    logic         gaps_on;
    int unsigned  stall_request;
    int unsigned  stall_left;

    ntc_adc_to_temperature #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_resolution_mode  (cfg_resolution_mode),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_adc_average        (s_adc_average),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_temperature_tenths (m_temperature_tenths),
        .m_sensor_error       (m_sensor_error)
    );

    // 10 ns clock.
    always #5 aclk = ~aclk;

    // Predict the temperature item for one reading under the given resolution.
    function automatic temp_item_t predict_temperature(input logic [11:0] reading,
                                                       input logic [1:0] mode);
        temp_item_t res;
        int x;
        int idx;
        int frac;
        int span;
        int num;
        int t;
        int mag;
        int step;
        int up_at;
        int rem;
        res.tenths = '0;
        res.fault = 1'b0;
        if (reading > ntcadc_pkg::ADC_HIGH_LIMIT || reading < ntcadc_pkg::ADC_LOW_LIMIT) begin
            // Open or shorted sensor: flag it and report zero.
            res.fault = 1'b1;
            return res;
        end
        // Clamp to the table ends, then walk to the first entry not above x.
        x = reading;
        if (x > ntcadc_pkg::NTC_ROM[0]) x = ntcadc_pkg::NTC_ROM[0];
        if (x < ntcadc_pkg::NTC_ROM[TABLE_ENTRIES-1]) x = ntcadc_pkg::NTC_ROM[TABLE_ENTRIES-1];
        idx = 0;
        while (idx < TABLE_ENTRIES - 1 && x < ntcadc_pkg::NTC_ROM[idx]) idx++;
        // Interpolate tenths inside the degree, rounding up past half the span.
        frac = 0;
        if (idx != 0 && ntcadc_pkg::NTC_ROM[idx-1] > ntcadc_pkg::NTC_ROM[idx] &&
            x >= ntcadc_pkg::NTC_ROM[idx]) begin
            span = ntcadc_pkg::NTC_ROM[idx-1] - ntcadc_pkg::NTC_ROM[idx];
            num = (x - ntcadc_pkg::NTC_ROM[idx]) * 10;
            frac = num / span;
            if (num % span > span / 2) frac++;
        end
        t = (idx - int'(ntcadc_pkg::ZERO_C_INDEX)) * 10 - frac;
        // Round symmetrically about zero; the spare code leaves tenths as they are.
        step = 0;
        up_at = 0;
        case (mode)
            ntcadc_pkg::RES_HALF: begin
                step = 5;
                up_at = 3;
            end
            ntcadc_pkg::RES_WHOLE: begin
                step = 10;
                up_at = 5;
            end
            default: step = 0;
        endcase
        if (step != 0) begin
            mag = (t < 0) ? -t : t;
            rem = mag % step;
            mag = mag - rem;
            if (rem >= up_at) mag = mag + step;
            t = (t < 0) ? -mag : mag;
        end
        res.tenths = 12'(t);
        return res;
    endfunction

    // Pick a reading: mostly inside the table, the rest in the clamp zones,
    // around the fault limits, or anywhere in the 12-bit range.
    function automatic logic [11:0] pick_reading();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70) return 12'($urandom_range(3568, 236));
        if (sel < 80) begin
            if ($urandom_range(1) == 0) return 12'($urandom_range(235, 8));
            return 12'($urandom_range(4087, 3569));
        end
        if (sel < 90) begin
            if ($urandom_range(1) == 0) return 12'($urandom_range(7, 0));
            return 12'($urandom_range(4095, 4088));
        end
        return 12'($urandom_range(4095, 0));
    endfunction

    // Offer one reading and hold it until accepted; returns at a falling edge
    // with valid still high so back-to-back items need no extra assignment.
    task automatic send_reading(input logic [11:0] reading);
        if (gaps_on) begin
            while ($urandom_range(99) < 15) begin
                s_valid = 1'b0;
                @(negedge aclk);
            end
        end
        s_valid = 1'b1;
        s_adc_average = reading;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_temps.push_back(predict_temperature(reading, res_mode));
        @(negedge aclk);
    endtask

    // Drop valid at the end of a burst.
    task automatic stop_readings();
        s_valid = 1'b0;
    endtask

    // Wait until every predicted temperature has come back, then settle.
    task automatic wait_drained();
        while (pending_temps.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write the resolution register while nothing is in flight.
    task automatic write_resolution(input logic [1:0] mode);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_resolution_mode = mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        res_mode = mode;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Fault window edges, table clamps, exact table points and alternating bits.
    task automatic test_fault_and_clamp();
        logic [11:0] boundary_readings [15];
        boundary_readings = '{12'd0, 12'd7, 12'd8, 12'd9, 12'd235, 12'd236, 12'd237,
                              12'd2996, 12'd3568, 12'd3569, 12'd4087, 12'd4088,
                              12'd4095, 12'hAAA, 12'h555};
        write_resolution(ntcadc_pkg::RES_TENTH);
        foreach (boundary_readings[i]) send_reading(boundary_readings[i]);
        stop_readings();
    endtask

    // Readings just either side of 0 C land on the rounding half steps,
    // negative and positive; run them under each rounding and the spare code.
    task automatic test_resolution_steps();
        write_resolution(ntcadc_pkg::RES_HALF);
        send_reading(12'd3006);
        send_reading(12'd3010);
        send_reading(12'd2979);
        stop_readings();
        write_resolution(ntcadc_pkg::RES_WHOLE);
        send_reading(12'd3013);
        send_reading(12'd3010);
        send_reading(12'd2979);
        stop_readings();
        write_resolution(ntcadc_pkg::RES_SPARE);
        send_reading(12'd3006);
        send_reading(12'd2979);
        stop_readings();
    endtask

    // Hold off the receiver for a long stretch while readings keep coming,
    // so the output register fills and the input stalls.
    task automatic test_output_stall();
        write_resolution(ntcadc_pkg::RES_WHOLE);
        gaps_on = 1'b0;
        stall_request = 600;
        repeat (12) send_reading(pick_reading());
        stop_readings();
        gaps_on = 1'b1;
    endtask

    // Random readings in phases, one resolution per phase; one phase runs
    // with no idling on either side.
    task automatic test_random_readings();
        logic [1:0] mode;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mode = (p < 4) ? 2'(p) : 2'($urandom_range(3));
            write_resolution(mode);
            gaps_on = (p != 2);
            repeat (PHASE_ITEMS) send_reading(pick_reading());
            stop_readings();
        end
        gaps_on = 1'b1;
    endtask

    // Receiver: honor a hold-off request first, else stall at random.
    always @(negedge aclk) begin
        if (stall_request != 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if (gaps_on) begin
            m_ready = ($urandom_range(99) >= 15);
        end else begin
            m_ready = 1'b1;
        end
    end

    // Check each accepted result item against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_temps.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected item: expected none, actual tenths %0d error %0b",
                         $time, m_temperature_tenths, m_sensor_error);
            end else begin
                if (m_temperature_tenths !== pending_temps[0].tenths) begin
                    mismatch_count++;
                    $display("%0t: temperature_tenths mismatch: expected %0d, actual %0d",
                             $time, pending_temps[0].tenths, m_temperature_tenths);
                end
                if (m_sensor_error !== pending_temps[0].fault) begin
                    mismatch_count++;
                    $display("%0t: sensor_error mismatch: expected %0b, actual %0b",
                             $time, pending_temps[0].fault, m_sensor_error);
                end
                void'(pending_temps.pop_front());
            end
        end
    end

    // Abort on a hung run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Reset once, then run the tests in turn and report.
    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_resolution_mode = ntcadc_pkg::RES_TENTH;
        s_valid = 1'b0;
        s_adc_average = '0;
        m_ready = 1'b0;
        res_mode = ntcadc_pkg::RES_TENTH;
        mismatch_count = 0;
        gaps_on = 1'b1;
        stall_request = 0;
        stall_left = 0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_fault_and_clamp();
        test_resolution_steps();
        test_output_stall();
        test_random_readings();

        // Drain, then give the block time to show any stray item.
        wait_drained();
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0 && pending_temps.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### ntc_adc_to_temperature.f
src/ntcadc_pkg.sv
src/ntc_adc_to_temperature.sv
dv/tb.sv
